// ===== sv/nrtl_pkg.sv =====
// Shared types and constants of the routing table lookup block.
package nrtl_pkg;

  localparam int NUM_VCS = 4;
  localparam int VC_W    = 2;

  localparam logic [6:0] SRC_WILD = 7'h7F;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_ROUTE  = 2'd1;
  localparam logic [1:0] REQ_CHECK  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_ROUTE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_CHK_FAIL = 2'd3;

  typedef struct packed {
    logic [6:0] src;
    logic [2:0] port;
    logic [2:0] vc;
  } entry_t;

endpackage

// ===== sv/nrtl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module nrtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/noc_routing_table_lookup.sv =====
// Routing table of a network-on-chip router: append, route lookup and completeness check.
//
// Input words arrive on s_axis (tuser = request kind), results leave on m_axis, one word
// or more per append, route or check request, tlast on the final one. router_count is
// written on the cfg channel, by the user only while the block is idle (the block does
// not enforce it); cfg is always ready. One request is worked on at a time; the counts
// per destination and the entries sit in two RAMs with registered reads, so the entry
// walk reads one entry a cycle. From accept to the first result in the output register:
//   append: S_CNT, then S_EMIT
//   route:  S_CNT, S_WALK over n entries of the destination (up to ENTRIES_PER_DEST),
//           S_EMIT; a wildcard VC adds NUM_VCS - 1 words, one a cycle unless stalled
//   check:  S_CHK, S_CNT and S_WALK for each checked destination, then S_CHK and S_EMIT
// A new request is taken the cycle after the last result is loaded, while that
// result still waits in the output register. A stalled receiver holds the output
// register and the block waits in its emit state.
// After reset S_INIT sweeps the count RAM and clears every address; no request is
// accepted during that sweep. router_count resets to 64.
module noc_routing_table_lookup #(
  parameter int MAX_ROUTERS      = 64,
  parameter int ENTRIES_PER_DEST = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // dest[5:0], source[12:6], entry_port[15:13], entry_vc[18:16],
  // arriving_port[21:19], arriving_vc[23:22]
  input  logic [23:0] s_axis_tdata_i,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[1:0], route_in_port[4:2], route_in_vc[6:5], route_port[9:7],
  // route_vc[11:10], zero[15:12]
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  localparam int DW  = $clog2(MAX_ROUTERS);
  localparam int IW  = (ENTRIES_PER_DEST > 1) ? $clog2(ENTRIES_PER_DEST) : 1;
  localparam int CW  = $clog2(ENTRIES_PER_DEST + 1);
  localparam int EAW = DW + IW;
  localparam int EDEPTH = MAX_ROUTERS * (2 ** IW);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_CNT, S_CHK, S_WALK, S_EMIT
  } state_e;

  state_e state_q;

  logic [6:0]  rc_q;
  logic [1:0]  req_q;
  logic [6:0]  src_q;
  logic [2:0]  eport_q;
  logic [2:0]  evc_q;
  logic [2:0]  aport_q;
  logic [1:0]  avc_q;
  logic        dest_ok_q;
  logic [DW-1:0] didx_q;
  logic [DW-1:0] init_q;
  logic [IW-1:0] idx_q;
  logic [CW-1:0] cnt_q;
  logic [6:0]  d_q;
  logic [7:0]  tally_q;
  logic        found_q;
  logic [2:0]  rport_q;
  logic [2:0]  rvc_q;
  logic [1:0]  st_q;
  logic [nrtl_pkg::VC_W-1:0] k_q;

  logic        m_tvalid_q;
  logic [15:0] m_tdata_q;
  logic        m_tlast_q;

  logic          s_fire;
  logic          out_free;
  logic [5:0]    in_dest;
  logic          cnt_we;
  logic [DW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;
  logic [DW-1:0] cnt_raddr;
  logic [CW-1:0] cnt_rd;
  logic          ent_we;
  logic [EAW-1:0] ent_waddr;
  logic [EAW-1:0] ent_raddr;
  logic [12:0]   ent_rd;
  nrtl_pkg::entry_t ent;
  nrtl_pkg::entry_t ent_wr;
  logic          match;
  logic          walk_last;
  logic [7:0]    tally_nx;
  logic [2:0]    fport;
  logic [2:0]    fvc;
  logic          append_ok;
  logic          expand;
  logic          emit_last;
  logic [2:0]    o_in_port;
  logic [1:0]    o_in_vc;
  logic [1:0]    o_vc;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_tvalid_q || m_axis_tready_i;
  assign in_dest         = s_axis_tdata_i[5:0];
  assign cfg_ready_o     = 1'b1;

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tlast_o  = m_tlast_q;

  assign ent       = nrtl_pkg::entry_t'(ent_rd);
  assign match     = (ent.src == nrtl_pkg::SRC_WILD) || (ent.src == src_q);
  assign walk_last = ((CW'(idx_q) + CW'(1)) == cnt_q);
  assign tally_nx  = (ent.src == nrtl_pkg::SRC_WILD) ? {1'b0, rc_q} : tally_q + 8'd1;
  assign fport     = match ? ent.port : rport_q;
  assign fvc       = match ? ent.vc : rvc_q;
  assign append_ok = dest_ok_q && (cnt_rd < CW'(ENTRIES_PER_DEST));

  assign expand    = rvc_q[2];
  assign emit_last = !expand || (k_q == nrtl_pkg::VC_W'(nrtl_pkg::NUM_VCS - 1));
  assign o_in_port = (req_q == nrtl_pkg::REQ_ROUTE) ? aport_q : 3'd0;
  assign o_in_vc   = (req_q == nrtl_pkg::REQ_ROUTE) ? avc_q : 2'd0;
  assign o_vc      = expand ? k_q : rvc_q[1:0];

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = didx_q;
    cnt_wdata = cnt_rd + CW'(1);
    if (state_q == S_INIT) begin
      cnt_we    = 1'b1;
      cnt_waddr = init_q;
      cnt_wdata = '0;
    end else if (state_q == S_CNT && req_q == nrtl_pkg::REQ_APPEND && append_ok) begin
      cnt_we = 1'b1;
    end
  end

  assign cnt_raddr = (state_q == S_CHK) ? DW'(d_q) : DW'(in_dest);

  assign ent_we    = (state_q == S_CNT) && (req_q == nrtl_pkg::REQ_APPEND) && append_ok;
  assign ent_waddr = {didx_q, IW'(cnt_rd)};
  assign ent_wr    = '{src: src_q, port: eport_q, vc: evc_q};
  assign ent_raddr = (state_q == S_WALK) ? {didx_q, idx_q + IW'(1)} : {didx_q, IW'(0)};

  nrtl_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_ROUTERS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rd)
  );

  nrtl_ram #(
    .WIDTH (13),
    .DEPTH (EDEPTH)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wr),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      init_q     <= '0;
      rc_q       <= 7'd64;
      m_tvalid_q <= 1'b0;
      k_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        rc_q <= cfg_data_i;
      end
      if (m_axis_tready_i && state_q != S_EMIT) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          init_q <= init_q + DW'(1);
          if (init_q == DW'(MAX_ROUTERS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_fire) begin
            req_q     <= s_axis_tuser_i;
            src_q     <= s_axis_tdata_i[12:6];
            eport_q   <= s_axis_tdata_i[15:13];
            evc_q     <= s_axis_tdata_i[18:16];
            aport_q   <= s_axis_tdata_i[21:19];
            avc_q     <= s_axis_tdata_i[23:22];
            didx_q    <= DW'(in_dest);
            dest_ok_q <= (32'(in_dest) < MAX_ROUTERS);
            d_q       <= '0;
            found_q   <= 1'b0;
            rport_q   <= '0;
            rvc_q     <= '0;
            k_q       <= '0;
            priority if (s_axis_tuser_i == nrtl_pkg::REQ_CHECK) begin
              state_q <= S_CHK;
            end else if (s_axis_tuser_i == nrtl_pkg::REQ_APPEND ||
                         s_axis_tuser_i == nrtl_pkg::REQ_ROUTE) begin
              state_q <= S_CNT;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_CHK: begin
          priority if (d_q >= rc_q) begin
            st_q    <= nrtl_pkg::ST_OK;
            state_q <= S_EMIT;
          end else if (32'(d_q) >= MAX_ROUTERS) begin
            st_q    <= nrtl_pkg::ST_CHK_FAIL;
            state_q <= S_EMIT;
          end else begin
            didx_q  <= DW'(d_q);
            state_q <= S_CNT;
          end
        end
        S_CNT: begin
          cnt_q   <= cnt_rd;
          idx_q   <= '0;
          tally_q <= '0;
          unique case (req_q)
            nrtl_pkg::REQ_APPEND: begin
              st_q    <= append_ok ? nrtl_pkg::ST_OK : nrtl_pkg::ST_FULL;
              state_q <= S_EMIT;
            end
            nrtl_pkg::REQ_ROUTE: begin
              if (!dest_ok_q || cnt_rd == '0) begin
                st_q    <= nrtl_pkg::ST_NO_ROUTE;
                state_q <= S_EMIT;
              end else begin
                state_q <= S_WALK;
              end
            end
            default: begin
              if (cnt_rd == '0) begin
                st_q    <= nrtl_pkg::ST_CHK_FAIL;
                state_q <= S_EMIT;
              end else begin
                state_q <= S_WALK;
              end
            end
          endcase
        end
        S_WALK: begin
          idx_q   <= idx_q + IW'(1);
          tally_q <= tally_nx;
          if (req_q == nrtl_pkg::REQ_ROUTE) begin
            found_q <= found_q || match;
            rport_q <= fport;
            rvc_q   <= fvc;
            if (walk_last) begin
              if (found_q || match) begin
                st_q <= nrtl_pkg::ST_OK;
              end else begin
                st_q <= nrtl_pkg::ST_NO_ROUTE;
              end
              state_q <= S_EMIT;
            end
          end else if (walk_last) begin
            if (tally_nx != {1'b0, rc_q}) begin
              st_q    <= nrtl_pkg::ST_CHK_FAIL;
              state_q <= S_EMIT;
            end else begin
              d_q     <= d_q + 7'd1;
              state_q <= S_CHK;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= {4'd0, o_vc, rport_q, o_in_vc, o_in_port, st_q};
            m_tlast_q  <= emit_last;
            k_q        <= emit_last ? '0 : k_q + nrtl_pkg::VC_W'(1);
            if (emit_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (CW'(idx_q) < cnt_q))
    else $error("entry walk beyond destination count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |-> (cnt_wdata <= CW'(ENTRIES_PER_DEST)))
    else $error("destination count above list size");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (s_axis_tuser_i == nrtl_pkg::REQ_APPEND ||
                s_axis_tuser_i == nrtl_pkg::REQ_ROUTE ||
                s_axis_tuser_i == nrtl_pkg::REQ_CHECK)) |=> !s_axis_tready_o)
    else $error("request taken while another is in progress");

  a_no_output_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !m_tvalid_q)
    else $error("result word during count clearing sweep");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the routing table lookup block.
`timescale 1ns / 1ps

module tb;

  localparam int DESTS     = 64;
  localparam int LIST_LEN  = 8;
  localparam int STALL_LEN = 300;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int         VC_ALL   = 7;
  localparam int         SRC_ANY  = int'(nrtl_pkg::SRC_WILD);

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] dest;
    logic [6:0] src;
    logic [2:0] eport;
    logic [2:0] evc;
    logic [2:0] aport;
    logic [1:0] avc;
  } rt_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] in_port;
    logic [1:0] in_vc;
    logic [2:0] port;
    logic [1:0] vc;
    logic       last;
  } rt_word_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i  = '0;
  logic [1:0]  s_axis_tuser_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i      = '0;

  logic no_idle   = 1'b0;
  logic stall_tog = 1'b0;
  logic stall_seen = 1'b0;
  int   hold_left = 0;
  int   bad_words = 0;

  // predicted table contents
  logic [6:0]  ent_src  [DESTS][LIST_LEN];
  logic [2:0]  ent_port [DESTS][LIST_LEN];
  logic [2:0]  ent_vc   [DESTS][LIST_LEN];
  int          ent_cnt  [DESTS];
  logic [6:0]  router_count_m = 7'd64;
  rt_word_t    route_q[$];

  noc_routing_table_lookup #(
    .MAX_ROUTERS     (DESTS),
    .ENTRIES_PER_DEST(LIST_LEN)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void push_word(logic [1:0] st, logic [2:0] ip, logic [1:0] iv,
                                    logic [2:0] p, logic [1:0] v, logic l);
    rt_word_t w;
    w.status  = st;
    w.in_port = ip;
    w.in_vc   = iv;
    w.port    = p;
    w.vc      = v;
    w.last    = l;
    route_q.push_back(w);
  endfunction

  // Applies one accepted request to the predicted table and queues its words.
  function automatic void table_step(rt_req_t r);
    logic       hit;
    logic [2:0] hp;
    logic [2:0] hv;
    int         tally;
    logic       ok;
    hit = 1'b0;
    hp  = '0;
    hv  = '0;
    ok  = 1'b1;
    case (r.kind)
      nrtl_pkg::REQ_APPEND: begin
        if (ent_cnt[r.dest] >= LIST_LEN) begin
          push_word(nrtl_pkg::ST_FULL, '0, '0, '0, '0, 1'b1);
        end else begin
          ent_src[r.dest][ent_cnt[r.dest]]  = r.src;
          ent_port[r.dest][ent_cnt[r.dest]] = r.eport;
          ent_vc[r.dest][ent_cnt[r.dest]]   = r.evc;
          ent_cnt[r.dest]++;
          push_word(nrtl_pkg::ST_OK, '0, '0, '0, '0, 1'b1);
        end
      end
      nrtl_pkg::REQ_ROUTE: begin
        for (int i = 0; i < ent_cnt[r.dest]; i++) begin
          if (ent_src[r.dest][i] == nrtl_pkg::SRC_WILD || ent_src[r.dest][i] == r.src) begin
            hit = 1'b1;
            hp  = ent_port[r.dest][i];
            hv  = ent_vc[r.dest][i];
          end
        end
        if (!hit) begin
          push_word(nrtl_pkg::ST_NO_ROUTE, r.aport, r.avc, '0, '0, 1'b1);
        end else if (hv[2]) begin
          for (int k = 0; k < nrtl_pkg::NUM_VCS; k++)
            push_word(nrtl_pkg::ST_OK, r.aport, r.avc, hp, k[1:0],
                      k == nrtl_pkg::NUM_VCS - 1);
        end else begin
          push_word(nrtl_pkg::ST_OK, r.aport, r.avc, hp, hv[1:0], 1'b1);
        end
      end
      nrtl_pkg::REQ_CHECK: begin
        for (int d = 0; d < int'(router_count_m) && ok; d++) begin
          if (d >= DESTS) begin
            ok = 1'b0;
          end else if (ent_cnt[d] == 0) begin
            ok = 1'b0;
          end else begin
            tally = 0;
            for (int i = 0; i < ent_cnt[d]; i++) begin
              if (ent_src[d][i] == nrtl_pkg::SRC_WILD) tally = int'(router_count_m);
              else tally++;
            end
            if (tally != int'(router_count_m)) ok = 1'b0;
          end
        end
        push_word(ok ? nrtl_pkg::ST_OK : nrtl_pkg::ST_CHK_FAIL, '0, '0, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic rt_req_t mk(logic [1:0] k, int d, int s, int ep, int ev, int ap,
                                 int av);
    rt_req_t r;
    r.kind  = k;
    r.dest  = 6'(d);
    r.src   = 7'(s);
    r.eport = 3'(ep);
    r.evc   = 3'(ev);
    r.aport = 3'(ap);
    r.avc   = 2'(av);
    return r;
  endfunction

  function automatic rt_req_t rand_req();
    rt_req_t r;
    int      pick;
    pick   = $urandom_range(0, 99);
    if (pick < 40)      r.kind = nrtl_pkg::REQ_APPEND;
    else if (pick < 86) r.kind = nrtl_pkg::REQ_ROUTE;
    else if (pick < 94) r.kind = nrtl_pkg::REQ_CHECK;
    else                r.kind = REQ_NONE;
    r.dest = $urandom_range(0, 1) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
    pick   = $urandom_range(0, 9);
    if (pick < 2)      r.src = nrtl_pkg::SRC_WILD;
    else if (pick < 7) r.src = 7'($urandom_range(0, 3));
    else               r.src = 7'($urandom_range(0, 63));
    r.eport = $urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    r.evc   = $urandom_range(0, 3) == 0 ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
    r.aport = 3'($urandom_range(0, 4));
    r.avc   = 2'($urandom_range(0, 3));
    return r;
  endfunction

  task automatic send_req(rt_req_t r);
    while (!no_idle && $urandom_range(0, 99) < 24) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {r.avc, r.aport, r.evc, r.eport, r.src, r.dest};
    s_axis_tuser_i  <= r.kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    table_step(r);
  endtask

  // Drops valid in the step of the last handshake, then waits out the queue.
  task automatic wait_results_drained(int extra);
    s_axis_tvalid_i <= 1'b0;
    while (route_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic set_router_count(logic [6:0] v);
    wait_results_drained(40);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i    <= 1'b0;
    router_count_m = v;
  endtask

  // Receiver: checks each accepted word and drives tready.
  always @(posedge clk_i) begin
    rt_word_t got;
    rt_word_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.status  = m_axis_tdata_o[1:0];
      got.in_port = m_axis_tdata_o[4:2];
      got.in_vc   = m_axis_tdata_o[6:5];
      got.port    = m_axis_tdata_o[9:7];
      got.vc      = m_axis_tdata_o[11:10];
      got.last    = m_axis_tlast_o;
      if (route_q.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("unexpected word: st=%0d in=%0d/%0d out=%0d/%0d last=%0d",
                   got.status, got.in_port, got.in_vc, got.port, got.vc, got.last);
      end else begin
        want = route_q.pop_front();
        if (got !== want) begin
          bad_words++;
          if (bad_words <= 10)
            $display("mismatch: exp %0d %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d %0d",
                     want.status, want.in_port, want.in_vc, want.port, want.vc, want.last,
                     got.status, got.in_port, got.in_vc, got.port, got.vc, got.last);
        end
      end
    end
    if (stall_tog != stall_seen) begin
      stall_seen = stall_tog;
      hold_left  = STALL_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= no_idle || ($urandom_range(0, 99) >= 24);
    end
  end

  task automatic test_table_basics();
    send_req(mk(nrtl_pkg::REQ_CHECK, 0, 0, 0, 0, 0, 0));
    send_req(mk(nrtl_pkg::REQ_ROUTE, 40, 7, 0, 0, 4, 3));
    send_req(mk(nrtl_pkg::REQ_APPEND, 40, SRC_ANY, 7, VC_ALL, 0, 0));
    send_req(mk(nrtl_pkg::REQ_ROUTE, 40, 7, 0, 0, 0, 0));
    send_req(mk(nrtl_pkg::REQ_APPEND, 40, 5, 2, 3, 0, 0));
    send_req(mk(nrtl_pkg::REQ_ROUTE, 40, 5, 0, 0, 2, 1));
    send_req(mk(nrtl_pkg::REQ_ROUTE, 40, 6, 0, 0, 1, 2));
    send_req(mk(nrtl_pkg::REQ_ROUTE, 40, SRC_ANY, 0, 0, 3, 0));
    send_req(mk(nrtl_pkg::REQ_APPEND, 40, 63, 4, 4, 0, 0));
    send_req(mk(nrtl_pkg::REQ_ROUTE, 40, 63, 0, 0, 3, 2));
    send_req(mk(nrtl_pkg::REQ_APPEND, 63, 0, 0, 0, 0, 0));
    send_req(mk(nrtl_pkg::REQ_ROUTE, 63, 0, 0, 0, 4, 3));
    send_req(mk(nrtl_pkg::REQ_ROUTE, 63, 1, 0, 0, 2, 2));
    send_req(mk(REQ_NONE, 63, 0, 7, 7, 4, 3));
    // fill one list past its end; the eighth entry is a wildcard
    for (int i = 0; i < LIST_LEN + 1; i++)
      send_req(mk(nrtl_pkg::REQ_APPEND, 41, i == 7 ? SRC_ANY : i, i == 7 ? 5 : i % 5,
                  i == 7 ? 6 : i % 4, 0, 0));
    send_req(mk(nrtl_pkg::REQ_ROUTE, 41, 3, 0, 0, 1, 1));
  endtask

  task automatic test_completeness();
    set_router_count(7'd0);
    send_req(mk(nrtl_pkg::REQ_CHECK, 0, 0, 0, 0, 0, 0));
    set_router_count(7'd1);
    send_req(mk(nrtl_pkg::REQ_CHECK, 0, 0, 0, 0, 0, 0));
    send_req(mk(nrtl_pkg::REQ_APPEND, 0, 3, 1, 1, 0, 0));
    send_req(mk(nrtl_pkg::REQ_CHECK, 0, 0, 0, 0, 0, 0));
    set_router_count(7'd2);
    send_req(mk(nrtl_pkg::REQ_CHECK, 0, 0, 0, 0, 0, 0));
    send_req(mk(nrtl_pkg::REQ_APPEND, 0, SRC_ANY, 2, 2, 0, 0));
    send_req(mk(nrtl_pkg::REQ_CHECK, 0, 0, 0, 0, 0, 0));
    send_req(mk(nrtl_pkg::REQ_APPEND, 1, 0, 3, 0, 0, 0));
    send_req(mk(nrtl_pkg::REQ_APPEND, 1, 1, 4, VC_ALL, 0, 0));
    send_req(mk(nrtl_pkg::REQ_CHECK, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_output_stall();
    send_req(mk(nrtl_pkg::REQ_APPEND, 50, SRC_ANY, 3, VC_ALL, 0, 0));
    wait_results_drained(0);
    no_idle   <= 1'b1;
    stall_tog <= ~stall_tog;
    for (int i = 0; i < 8; i++)
      send_req(mk(nrtl_pkg::REQ_ROUTE, 50, $urandom_range(0, 63), 0, 0,
                  $urandom_range(0, 4), $urandom_range(0, 3)));
    s_axis_tvalid_i <= 1'b0;
    no_idle         <= 1'b0;
  endtask

  task automatic test_full_table();
    set_router_count(7'd64);
    for (int d = 0; d < DESTS; d++)
      if (ent_cnt[d] < LIST_LEN)
        send_req(mk(nrtl_pkg::REQ_APPEND, d, SRC_ANY, $urandom_range(0, 4),
                    $urandom_range(0, 7), 0, 0));
    send_req(mk(nrtl_pkg::REQ_CHECK, 0, 0, 0, 0, 0, 0));
    set_router_count(7'd127);
    send_req(mk(nrtl_pkg::REQ_CHECK, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic();
    rt_req_t r;
    int      n;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: set_router_count(7'd1);
        1: set_router_count(7'd64);
        default: set_router_count(7'($urandom_range(2, 63)));
      endcase
      no_idle <= (ph == 2);
      n = 0;
      while (n < 8) begin
        r = rand_req();
        if (r.kind == nrtl_pkg::REQ_APPEND && $urandom_range(0, 2) == 0) begin
          send_req(r);
          n++;
          r.kind = nrtl_pkg::REQ_ROUTE;
        end
        send_req(r);
        if (r.kind != REQ_NONE) n++;
        if (n == 4 && ph == 1) wait_results_drained(0);
      end
    end
    no_idle <= 1'b0;
  endtask

  initial begin
    foreach (ent_cnt[d]) ent_cnt[d] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_table_basics();
    test_completeness();
    test_output_stall();
    test_full_table();
    test_random_traffic();
    wait_results_drained(200);
    if (bad_words == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  initial begin
    #1000000;
    $display("tb failed");
    $finish;
  end

endmodule
